// ===== rtl/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types and constants for the RC-channels frame receiver.
// ----------------------------------------------------------------------------
package crsf_pkg;

  localparam int STORE_DEPTH   = 25;
  localparam int FIRST_PAYLOAD = 3;
  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
  localparam int VALUE_W       = 11;

  localparam logic [6:0] COUNT_WRAP = 7'd67;
  localparam logic [9:0] IDLE_MAX   = 10'd1023;

  // input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // configuration register indexes
  localparam logic [7:0] REG_ADDRESS    = 8'd0;
  localparam logic [7:0] REG_TYPE       = 8'd1;
  localparam logic [7:0] REG_MAX_LENGTH = 8'd2;
  localparam logic [7:0] REG_GAP_LIMIT  = 8'd3;

  localparam logic [7:0] RST_ADDRESS    = 8'hC8;
  localparam logic [7:0] RST_TYPE       = 8'h16;
  localparam logic [6:0] RST_MAX_LENGTH = 7'd64;
  localparam logic [9:0] RST_GAP_LIMIT  = 10'd800;

  typedef struct packed {
    logic [7:0] expected_address;
    logic [7:0] expected_type;
    logic [6:0] max_length;
    logic [9:0] gap_limit;
  } cfg_t;

  typedef struct packed {
    logic                    hit;      // item completes a matching frame
    logic [PAYLOAD_BITS-1:0] payload;  // frame bytes 3..24, byte 3 lowest
  } frame_t;

endpackage

// ===== rtl/crsf_framer.sv =====
// ----------------------------------------------------------------------------
// crsf_framer
// Byte framing, idle gap timing and frame byte store. Flags the item that
// completes a frame with matching address and type, and shows its payload.
// ----------------------------------------------------------------------------
module crsf_framer (
  input  logic            clk,
  input  logic            rst,
  input  crsf_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic            mode,
  input  logic [7:0]      rx_byte,
  output crsf_pkg::frame_t frame
);

  logic [6:0] write_position;
  logic [6:0] frame_length;
  logic [9:0] idle_ticks;
  logic [7:0] byte_store [crsf_pkg::STORE_DEPTH];

  logic [7:0] store_next [crsf_pkg::STORE_DEPTH];
  logic [6:0] pos_w;
  logic [6:0] pos_inc;
  logic [6:0] len_next;
  logic       len_drop;
  logic       done;
  logic [9:0] idle_next;

  always_comb begin
    pos_w    = (write_position >= crsf_pkg::COUNT_WRAP) ? 7'd0 : write_position;
    len_drop = (pos_w == 7'd1) && (rx_byte > {1'b0, cfg.max_length});
    len_next = (pos_w == 7'd1) ? rx_byte[6:0] : frame_length;
    pos_inc  = pos_w + 7'd1;
    done     = !len_drop && (pos_inc > 7'd1) &&
               ({1'b0, pos_inc} >= ({1'b0, len_next} + 8'd2));
    idle_next = (idle_ticks == crsf_pkg::IDLE_MAX) ? idle_ticks : idle_ticks + 10'd1;

    store_next = byte_store;
    if (pos_w < 7'(crsf_pkg::STORE_DEPTH)) begin
      store_next[pos_w[4:0]] = rx_byte;
    end

    for (int i = 0; i < crsf_pkg::PAYLOAD_BYTES; i++) begin
      frame.payload[8*i +: 8] = store_next[crsf_pkg::FIRST_PAYLOAD + i];
    end
    frame.hit = (mode == crsf_pkg::MODE_BYTE) && done &&
                (store_next[0] == cfg.expected_address) &&
                (store_next[2] == cfg.expected_type);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      frame_length   <= '0;
      idle_ticks     <= '0;
      for (int i = 0; i < crsf_pkg::STORE_DEPTH; i++) begin
        byte_store[i] <= '0;
      end
    end else if (accept) begin
      if (mode == crsf_pkg::MODE_TICK) begin
        idle_ticks <= idle_next;
        // drop a partial frame after a long gap
        if (write_position != 7'd0 && idle_next > cfg.gap_limit) begin
          write_position <= '0;
          frame_length   <= '0;
        end
      end else begin
        idle_ticks <= '0;
        if (len_drop) begin
          write_position <= '0;
          frame_length   <= '0;
        end else begin
          byte_store <= store_next;
          if (done) begin
            write_position <= '0;
            frame_length   <= '0;
          end else begin
            write_position <= pos_inc;
            frame_length   <= len_next;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/crsf_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// Serial remote-control frame receiver with RC-channels unpack.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is either a received byte
// (mode 0, rx_byte) or a one-microsecond tick (mode 1). Bytes are framed,
// ticks time the idle gap. Up to one input beat is taken every cycle.
// Output channel (out_valid/out_ready): a complete frame with matching
// address and type yields CHANNEL_COUNT beats, channel 0 first, with
// last_channel set on the final one. The first beat is registered from the
// payload register; beats then follow one per cycle while out_ready is high.
// Channel beats are shifted out of a payload register, so while a frame is
// still being sent, in_ready drops only for a byte that would complete the
// next matching frame; all other beats keep flowing. A stalled receiver
// therefore holds the input only at frame boundaries.
// Configuration (cfg_valid/cfg_ready): always ready, one register per beat,
// indexes 0..3; other indexes are ignored.
// Reset clears framing state, the byte store and the idle counter, empties
// the output, and loads the default register values.
// ----------------------------------------------------------------------------
module crsf_frame_receiver #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        last_channel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam logic [3:0] LAST_IDX = 4'(CHANNEL_COUNT - 1);

  crsf_pkg::cfg_t   cfg;
  crsf_pkg::frame_t frame;

  logic                              busy;
  logic [3:0]                        beat_idx;
  logic [crsf_pkg::PAYLOAD_BITS-1:0] shift;
  logic                              in_accept;
  logic                              can_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = !(busy && frame.hit);
  assign in_accept = in_valid && in_ready;
  assign can_load  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_address <= crsf_pkg::RST_ADDRESS;
      cfg.expected_type    <= crsf_pkg::RST_TYPE;
      cfg.max_length       <= crsf_pkg::RST_MAX_LENGTH;
      cfg.gap_limit        <= crsf_pkg::RST_GAP_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        crsf_pkg::REG_ADDRESS:    cfg.expected_address <= cfg_data[7:0];
        crsf_pkg::REG_TYPE:       cfg.expected_type    <= cfg_data[7:0];
        crsf_pkg::REG_MAX_LENGTH: cfg.max_length       <= cfg_data[6:0];
        crsf_pkg::REG_GAP_LIMIT:  cfg.gap_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  crsf_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (in_accept),
    .mode    (mode),
    .rx_byte (rx_byte),
    .frame   (frame)
  );

  // channel emitter: shift 11 bits out per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      beat_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        if (busy) begin
          out_valid     <= 1'b1;
          channel_index <= beat_idx;
          channel_value <= shift[crsf_pkg::VALUE_W-1:0];
          last_channel  <= (beat_idx == LAST_IDX);
          shift         <= shift >> crsf_pkg::VALUE_W;
          if (beat_idx == LAST_IDX) begin
            busy <= 1'b0;
          end else begin
            beat_idx <= beat_idx + 4'd1;
          end
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (in_accept && frame.hit) begin
        busy     <= 1'b1;
        beat_idx <= '0;
        shift    <= frame.payload;
      end
    end
  end

endmodule

// ===== rtl/crsf_checker.sv =====
// ----------------------------------------------------------------------------
// crsf_checker
// Port-level checks on the channel beat stream of the frame receiver.
// ----------------------------------------------------------------------------
module crsf_checker #(
  parameter int CHANNEL_COUNT = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  channel_index,
  input logic [10:0] channel_value,
  input logic        last_channel
);

  localparam logic [3:0] LAST_IDX = 4'(CHANNEL_COUNT - 1);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_index) &&
      $stable(channel_value) && $stable(last_channel))
    else $error("stalled channel beat changed");

  // last flag marks exactly the final channel
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_channel == (channel_index == LAST_IDX)))
    else $error("last_channel disagrees with channel_index");

  // a frame's beats are back to back, in channel order
  a_next_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_channel |=>
      out_valid && (channel_index == $past(channel_index) + 4'd1))
    else $error("channel beats not contiguous");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind crsf_frame_receiver crsf_checker #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_crsf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_index (channel_index),
  .channel_value (channel_value),
  .last_channel  (last_channel)
);

// ===== tb/crsf_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// crsf_frame_receiver_tb
// Self-checking bench for the RC-channels frame receiver. A scoreboard
// tracks framing, the byte store and the idle counter. From each accepted
// byte or tick it predicts the channel beats, then checks every output beat
// in order. The run steps through several register settings and idle
// patterns, and one long output hold-off.
// ----------------------------------------------------------------------------
module crsf_frame_receiver_tb;

  localparam int NUM_CHANNELS   = 16;
  localparam int PHASE_ITEMS    = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  class channel_scoreboard;
    typedef struct {
      logic [3:0]  idx;
      logic [10:0] value;
      logic        is_last;
    } beat_t;

    crsf_pkg::cfg_t regs;
    logic [6:0]     wr_pos;
    logic [6:0]     frame_len;
    logic [7:0]     store [crsf_pkg::STORE_DEPTH];
    logic [9:0]     idle_ticks;
    beat_t          expected_beats [$];
    int             mismatches;

    function new();
      regs.expected_address = crsf_pkg::RST_ADDRESS;
      regs.expected_type    = crsf_pkg::RST_TYPE;
      regs.max_length       = crsf_pkg::RST_MAX_LENGTH;
      regs.gap_limit        = crsf_pkg::RST_GAP_LIMIT;
      wr_pos     = '0;
      frame_len  = '0;
      idle_ticks = '0;
      mismatches = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [9:0] data);
      case (idx)
        crsf_pkg::REG_ADDRESS:    regs.expected_address = data[7:0];
        crsf_pkg::REG_TYPE:       regs.expected_type    = data[7:0];
        crsf_pkg::REG_MAX_LENGTH: regs.max_length       = data[6:0];
        crsf_pkg::REG_GAP_LIMIT:  regs.gap_limit        = data;
        default: ;
      endcase
    endfunction

    // unpack 11-bit channels, LSB first, from bytes 3..24 of the store
    function void unpack_channels();
      logic [crsf_pkg::PAYLOAD_BITS-1:0] payload;
      beat_t b;
      for (int j = 0; j < crsf_pkg::PAYLOAD_BYTES; j++)
        payload[j*8 +: 8] = store[crsf_pkg::FIRST_PAYLOAD + j];
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        b.idx     = 4'(k);
        b.value   = payload[k*crsf_pkg::VALUE_W +: crsf_pkg::VALUE_W];
        b.is_last = (k == NUM_CHANNELS - 1);
        expected_beats.push_back(b);
      end
    endfunction

    function void note_input(logic m, logic [7:0] data);
      if (m == crsf_pkg::MODE_TICK) begin
        if (idle_ticks < crsf_pkg::IDLE_MAX) idle_ticks++;
        if (wr_pos != 0 && idle_ticks > regs.gap_limit) begin
          wr_pos    = '0;
          frame_len = '0;
        end
        return;
      end
      idle_ticks = '0;
      if (wr_pos >= crsf_pkg::COUNT_WRAP) wr_pos = '0;
      if (wr_pos == 1) begin
        // oversized length byte: drop it and restart framing
        if (data > regs.max_length) begin
          wr_pos    = '0;
          frame_len = '0;
          return;
        end
        frame_len = data[6:0];
      end
      if (wr_pos < crsf_pkg::STORE_DEPTH) store[wr_pos] = data;
      wr_pos = wr_pos + 7'd1;
      if (wr_pos > 1 && int'(wr_pos) >= int'(frame_len) + 2) begin
        wr_pos    = '0;
        frame_len = '0;
        if (store[0] == regs.expected_address && store[2] == regs.expected_type)
          unpack_channels();
      end
    endfunction

    function void check_beat(logic [3:0] idx, logic [10:0] value, logic is_last);
      beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected channel beat: index %0d value %0d last %0b",
                   idx, value, is_last);
        return;
      end
      want = expected_beats.pop_front();
      if (want.idx !== idx || want.value !== value || want.is_last !== is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"channel beat differs: expected index %0d value %0d last %0b,",
                    " got index %0d value %0d last %0b"},
                   want.idx, want.value, want.is_last, idx, value, is_last);
      end
    endfunction

    function void count_missing();
      while (expected_beats.size() != 0) begin
        void'(expected_beats.pop_front());
        mismatches++;
        if (mismatches <= 10) $display("channel beat expected but never sent");
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        mode          = crsf_pkg::MODE_BYTE;
  logic [7:0]  rx_byte       = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last_channel;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index     = '0;
  logic [9:0]  cfg_data      = '0;

  channel_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  bit hold_req      = 1'b0;

  crsf_frame_receiver #(
    .CHANNEL_COUNT(NUM_CHANNELS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(mode, rx_byte);
      if (out_valid && out_ready) sb.check_beat(channel_index, channel_value, last_channel);
    end
  end

  // output side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("crsf_frame_receiver: mismatch");
    $finish;
  end

  task automatic send_item(logic m, logic [7:0] data);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(crsf_pkg::MODE_TICK, 8'($urandom));
  endtask

  // one frame; length varies, and unless well formed, address, type, oversized length and idle gaps vary
  task automatic send_frame(bit well_formed);
    int m;
    int len;
    int fill;
    logic [7:0] addr;
    logic [7:0] ftype;
    logic [7:0] data;
    m     = sb.regs.max_length;
    addr  = sb.regs.expected_address;
    ftype = sb.regs.expected_type;
    if (!well_formed && $urandom_range(99) < 15) addr = 8'($urandom);
    if (!well_formed && $urandom_range(99) < 15) ftype = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5:
        len = (m >= 22) ? $urandom_range(22, (m < 24) ? m : 24) : $urandom_range(0, m);
      6, 7: len = $urandom_range(0, m);
      8:    len = m;
      default: len = well_formed ? m : $urandom_range(m + 1, 255);
    endcase
    fill = $urandom_range(9);
    send_item(crsf_pkg::MODE_BYTE, addr);
    send_item(crsf_pkg::MODE_BYTE, 8'(len));
    if (len > m) return;
    for (int p = 2; p < len + 2; p++) begin
      if (!well_formed && $urandom_range(99) < 6) send_ticks($urandom_range(1, 3));
      data = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      send_item(crsf_pkg::MODE_BYTE, (p == 2) ? ftype : data);
    end
  endtask

  task automatic random_traffic(int budget);
    int first;
    int r;
    first = items_sent;
    while (items_sent - first < budget) begin
      r = $urandom_range(99);
      if (r < 65) begin
        send_frame(1'b0);
      end else if (r < 75) begin
        repeat ($urandom_range(1, 3)) send_item(crsf_pkg::MODE_BYTE, 8'($urandom));
      end else if (r < 85) begin
        send_ticks($urandom_range(1, 4));
      end else begin
        // partial frame, then, for a limit up to 64, a gap at or one tick past the limit
        send_item(crsf_pkg::MODE_BYTE, sb.regs.expected_address);
        send_item(crsf_pkg::MODE_BYTE, 8'($urandom_range(0, sb.regs.max_length)));
        if (sb.regs.gap_limit <= 64) send_ticks(sb.regs.gap_limit + $urandom_range(0, 1));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(logic [7:0] addr, logic [7:0] ftype, logic [6:0] max_len,
                              logic [9:0] gap);
    write_reg(crsf_pkg::REG_ADDRESS, 10'(addr));
    write_reg(crsf_pkg::REG_TYPE, 10'(ftype));
    write_reg(crsf_pkg::REG_MAX_LENGTH, 10'(max_len));
    write_reg(crsf_pkg::REG_GAP_LIMIT, gap);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: tick, oversized length, full frame of ones, short frame
    send_idle_pct = 34;
    recv_idle_pct = 62;
    send_item(crsf_pkg::MODE_TICK, 8'hFF);
    send_item(crsf_pkg::MODE_BYTE, crsf_pkg::RST_ADDRESS);
    send_item(crsf_pkg::MODE_BYTE, 8'(crsf_pkg::RST_MAX_LENGTH) + 8'd1);
    send_item(crsf_pkg::MODE_BYTE, crsf_pkg::RST_ADDRESS);
    send_item(crsf_pkg::MODE_BYTE, 8'd22);
    send_item(crsf_pkg::MODE_BYTE, crsf_pkg::RST_TYPE);
    repeat (21) send_item(crsf_pkg::MODE_BYTE, 8'hFF);
    send_item(crsf_pkg::MODE_BYTE, crsf_pkg::RST_ADDRESS);
    send_item(crsf_pkg::MODE_BYTE, 8'd1);
    send_item(crsf_pkg::MODE_BYTE, crsf_pkg::RST_TYPE);
    random_traffic(PHASE_ITEMS);
    drain();

    program_regs(8'h00, 8'hFF, 7'd64, 10'd1);
    random_traffic(PHASE_ITEMS);
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 34;
    program_regs(8'hFF, 8'hFF, 7'd0, 10'd1000);
    // idle ticks inside a frame, short of the limit
    send_item(crsf_pkg::MODE_BYTE, 8'hFF);
    send_ticks(12);
    random_traffic(PHASE_ITEMS);
    drain();

    program_regs(8'hC8, 8'h00, 7'd24, 10'd5);
    hold_req = 1'b1;
    send_frame(1'b1);
    send_frame(1'b1);
    random_traffic(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(8'($urandom), 8'($urandom), 7'($urandom_range(0, 64)),
                 10'($urandom_range(1, 1000)));
    random_traffic(PHASE_ITEMS);
    drain();

    program_regs(crsf_pkg::RST_ADDRESS, crsf_pkg::RST_TYPE, crsf_pkg::RST_MAX_LENGTH,
                 crsf_pkg::RST_GAP_LIMIT);
    random_traffic(PHASE_ITEMS);
    drain();

    sb.count_missing();
    if (sb.mismatches == 0)
      $display("crsf_frame_receiver: match");
    else
      $display("crsf_frame_receiver: mismatch");
    $finish;
  end

endmodule
